/* hdl/ucbs_pkg.sv */
// shared types and constants for the uniform cubic b-spline evaluator
// no dependencies; used by every module under hdl
package ucbs_pkg;

    localparam int T_BITS     = 14;
    localparam int QUO_W      = 20;   // segment (6 bits) and fraction (14 bits)
    localparam int DIV_STAGES = 20;   // one quotient bit per stage
    localparam int PROD_W     = 22;   // position times segment count
    localparam int PROD_LOW   = 6;    // product bits shifted in by the divider

    localparam logic [14:0] T_ONE      = 15'd16384;
    localparam logic [18:0] RECIP3     = 19'd349526;  // ceil(2^20 / 3)
    localparam logic [17:0] ROUND_BIAS = 18'd98304;   // 3 * 32768
    localparam logic signed [63:0] HALF_DEN = 64'sd13194139533312; // 3 * 2^42

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } opcode_t;

    typedef enum logic {
        CFG_SEGMENT_COUNT = 1'b0,
        CFG_RANGE_MAX     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                is_eval;
        logic                flag;
        logic [5:0]          seg_clamp;
        logic [PROD_W-1:0]   prod;
        logic [5:0]          index;
        logic [15:0]         value;
    } item_t;

    typedef struct packed {
        logic                valid;
        item_t               item;
        logic [15:0]         rem;
        logic [QUO_W-1:0]    quo;
    } div_stage_t;

endpackage

/* hdl/ucbs_front.sv */
// front end: accepts items, classifies them and queues them for the back end
// depends on ucbs_pkg
module ucbs_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // point_index, point_value, position, zero pad
    input  logic [0:0]           s_tuser,   // opcode
    input  logic [5:0]           sc_eff,
    input  logic [15:0]          range_max,
    input  logic                 pop,
    output logic                 item_valid,
    output ucbs_pkg::item_t      item
);

    ucbs_pkg::item_t  fifo_mem [4];
    ucbs_pkg::item_t  cls;
    logic [1:0]       wr_ptr_reg, wr_ptr_next;
    logic [1:0]       rd_ptr_reg, rd_ptr_next;
    logic [2:0]       count_reg, count_next;
    logic             push, pop_ok;
    logic [15:0]      pos;

    assign pos = s_tdata[37:22];

    always_comb begin
        cls.is_eval   = (s_tuser[0] == ucbs_pkg::OP_EVAL);
        cls.flag      = (range_max == 16'd0) || (pos >= range_max);
        cls.seg_clamp = sc_eff - 6'd1;
        cls.prod      = pos * sc_eff;
        cls.index     = s_tdata[5:0];
        cls.value     = s_tdata[21:6];
    end

    assign s_tready   = (count_reg != 3'd4);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != 3'd0);
    assign pop_ok     = pop && item_valid;
    assign item       = fifo_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'b0, push} - {2'b0, pop_ok};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/ucbs_divider.sv */
// pipelined restoring divider: position*segments*2^14 / range_max, one bit a stage
// depends on ucbs_pkg
module ucbs_divider (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  logic                   in_valid,
    input  ucbs_pkg::item_t        in_item,
    input  logic [15:0]            range_max,
    output ucbs_pkg::div_stage_t   out_stage
);

    ucbs_pkg::div_stage_t stg_in   [ucbs_pkg::DIV_STAGES];
    ucbs_pkg::div_stage_t stg_next [ucbs_pkg::DIV_STAGES];
    ucbs_pkg::div_stage_t stg_reg  [ucbs_pkg::DIV_STAGES];

    genvar i;
    generate
        for (i = 0; i < ucbs_pkg::DIV_STAGES; i++) begin : g_stage
            logic        bit_in;
            logic [16:0] trial;

            if (i == 0) begin : g_first
                // the top product bits are already below range_max
                always_comb begin
                    stg_in[i].valid = in_valid;
                    stg_in[i].item  = in_item;
                    stg_in[i].rem   = in_item.prod[ucbs_pkg::PROD_W-1:ucbs_pkg::PROD_LOW];
                    stg_in[i].quo   = '0;
                end
            end else begin : g_rest
                assign stg_in[i] = stg_reg[i-1];
            end

            if (i < ucbs_pkg::PROD_LOW) begin : g_bit
                assign bit_in = stg_in[i].item.prod[ucbs_pkg::PROD_LOW-1-i];
            end else begin : g_zero
                assign bit_in = 1'b0;
            end

            always_comb begin
                trial        = {stg_in[i].rem, bit_in};
                stg_next[i]  = stg_in[i];
                if (trial >= {1'b0, range_max}) begin
                    stg_next[i].rem = 16'(trial - {1'b0, range_max});
                    stg_next[i].quo = {stg_in[i].quo[ucbs_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    stg_next[i].rem = trial[15:0];
                    stg_next[i].quo = {stg_in[i].quo[ucbs_pkg::QUO_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stg_reg[i].valid <= 1'b0;
                end else if (adv) begin
                    stg_reg[i] <= stg_next[i];
                end
            end
        end
    endgenerate

    assign out_stage = stg_reg[ucbs_pkg::DIV_STAGES-1];

endmodule

/* hdl/ucbs_blend.sv */
// back end: point store in four banks, basis blend in horner form, rounding, output register
// depends on ucbs_pkg
module ucbs_blend #(
    parameter int POINTS = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    output logic                   adv,
    input  ucbs_pkg::div_stage_t   d,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // spline_value, segment_index, zero pad
    output logic [0:0]             m_tuser    // out_of_range
);

    localparam int BD = (POINTS + 3) / 4;
    localparam int AW = (BD > 1) ? $clog2(BD) : 1;

    // lookup stage
    logic [5:0]           seg;
    logic [14:0]          tval;
    logic [AW-1:0]        rd_addr [4];
    logic [AW-1:0]        wr_addr;
    logic                 wr_ok;
    logic [15:0]          rd_data_reg [4];

    always_comb begin
        seg     = d.item.flag ? d.item.seg_clamp : d.quo[ucbs_pkg::QUO_W-1:ucbs_pkg::T_BITS];
        tval    = d.item.flag ? ucbs_pkg::T_ONE : {1'b0, d.quo[ucbs_pkg::T_BITS-1:0]};
        wr_addr = AW'(d.item.index[5:2]);
        wr_ok   = adv && d.valid && !d.item.is_eval && (int'(d.item.index) < POINTS);
    end

    genvar b;
    generate
        for (b = 0; b < 4; b++) begin : g_bank
            logic [15:0] bank_mem [BD];
            logic [1:0]  off;
            logic [6:0]  idx;

            // each of the four points seg..seg+3 falls in a different bank
            always_comb begin
                off        = 2'(b) - seg[1:0];
                idx        = {1'b0, seg} + {5'b0, off};
                rd_addr[b] = AW'(idx[6:2]);
            end

            always_ff @(posedge aclk) begin
                if (wr_ok && (d.item.index[1:0] == 2'(b))) begin
                    bank_mem[wr_addr] <= d.item.value;
                end
                if (adv) begin
                    rd_data_reg[b] <= bank_mem[rd_addr[b]];
                end
            end
        end
    endgenerate

    // pipeline valid bits and side data
    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [5:0]        seg1_reg, seg2_reg, seg3_reg, seg4_reg, seg5_reg, seg6_reg, seg7_reg;
    logic              f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg, f7_reg;
    logic [1:0]        lo1_reg;
    logic signed [15:0] t1_reg, t2_reg, t3_reg, t4_reg;

    // coefficients of the cubic in t
    logic signed [19:0] p0, p1, p2, p3;
    logic signed [19:0] a0_next, a1_next, a2_next, a3_next;
    logic signed [19:0] a0_reg, a1_reg, a2_reg, a3_reg;
    logic signed [19:0] a0_h1_reg, a1_h1_reg, a0_h2_reg;

    always_comb begin
        p0 = 20'(signed'(rd_data_reg[lo1_reg]));
        p1 = 20'(signed'(rd_data_reg[2'(lo1_reg + 2'd1)]));
        p2 = 20'(signed'(rd_data_reg[2'(lo1_reg + 2'd2)]));
        p3 = 20'(signed'(rd_data_reg[2'(lo1_reg + 2'd3)]));
        a3_next = -p0 + 20'sd3 * p1 - 20'sd3 * p2 + p3;
        a2_next = 20'sd3 * p0 - 20'sd6 * p1 + 20'sd3 * p2;
        a1_next = 20'sd3 * (p2 - p0);
        a0_next = p0 + 20'sd4 * p1 + p2;
    end

    logic signed [35:0] mul1, h1_next, h1_reg;
    logic signed [51:0] mul2, h2_next, h2_reg;
    logic signed [67:0] mul3;
    logic signed [63:0] h3_next, h3_reg;
    logic signed [63:0] x_sum;
    logic signed [20:0] y_q;
    logic [17:0]        z_next, z_reg;
    logic [36:0]        prod_next, prod_reg;
    logic [16:0]        q_val;
    logic [15:0]        res;

    always_comb begin
        mul1    = a3_reg * t2_reg;
        h1_next = mul1 + {{2{a2_reg[19]}}, a2_reg, 14'b0};
        mul2    = h1_reg * t3_reg;
        h2_next = mul2 + {{4{a1_h1_reg[19]}}, a1_h1_reg, 28'b0};
        mul3    = h2_reg * t4_reg;
        h3_next = mul3[63:0] + {{2{a0_h2_reg[19]}}, a0_h2_reg, 42'b0};
        // divide by 6*2^42 with round half up: shift by 2^43, then divide by 3
        x_sum   = h3_reg + ucbs_pkg::HALF_DEN;
        y_q     = x_sum[63:43];
        z_next  = 18'(y_q + 21'(ucbs_pkg::ROUND_BIAS));
        prod_next = z_reg * ucbs_pkg::RECIP3;
        q_val   = prod_reg[36:20];
        res     = q_val[16] ? 16'h7fff : {~q_val[15], q_val[14:0]};
    end

    logic        m_tvalid_reg;
    logic [15:0] val_out_reg;
    logic [5:0]  seg_out_reg;
    logic        flag_out_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, seg_out_reg, val_out_reg};
    assign m_tuser  = flag_out_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo1_reg  <= seg[1:0];
            t1_reg   <= signed'({1'b0, tval});
            t2_reg   <= t1_reg;
            t3_reg   <= t2_reg;
            t4_reg   <= t3_reg;
            seg1_reg <= seg;       f1_reg <= d.item.flag;
            seg2_reg <= seg1_reg;  f2_reg <= f1_reg;
            seg3_reg <= seg2_reg;  f3_reg <= f2_reg;
            seg4_reg <= seg3_reg;  f4_reg <= f3_reg;
            seg5_reg <= seg4_reg;  f5_reg <= f4_reg;
            seg6_reg <= seg5_reg;  f6_reg <= f5_reg;
            seg7_reg <= seg6_reg;  f7_reg <= f6_reg;
            a0_reg   <= a0_next;
            a1_reg   <= a1_next;
            a2_reg   <= a2_next;
            a3_reg   <= a3_next;
            a0_h1_reg <= a0_reg;
            a1_h1_reg <= a1_reg;
            a0_h2_reg <= a0_h1_reg;
            h1_reg   <= h1_next;
            h2_reg   <= h2_next;
            h3_reg   <= h3_next;
            z_reg    <= z_next;
            prod_reg <= prod_next;
            val_out_reg  <= res;
            seg_out_reg  <= seg7_reg;
            flag_out_reg <= f7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            // load items end at the store
            v1_reg <= d.valid && d.item.is_eval;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            m_tvalid_reg <= v7_reg;
        end
    end

endmodule

/* hdl/uniform_cubic_bspline_eval.sv */
// Uniform cubic B-spline evaluator. Load items (tuser 0) write a signed Q8.8 control
// point; evaluate items (tuser 1) give one result with the spline value at a Q8.8
// position, the segment used and an out-of-range flag. The block takes one item per
// cycle and gives one result per cycle while the output is not stalled; an evaluate
// result passes the 20-stage divider (one quotient bit per stage), the bank read,
// the coefficient stage, three multiply stages of the cubic, two rounding stages and
// the output register. A short queue ahead of the divider absorbs output stalls.
// Control points that were never loaded read as unknown values. The user must write
// configuration only while the block idles; the block itself does not enforce it.
module uniform_cubic_bspline_eval #(
    parameter int POINTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,    // point_index, point_value, position, zero pad
    input  logic [0:0]   s_tuser,    // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,    // spline_value, segment_index, zero pad
    output logic [0:0]   m_tuser,    // out_of_range
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam logic [5:0] SC_MAX = (POINTS - 3 > 63) ? 6'd63 : 6'(POINTS - 3);

    logic [5:0]  segment_count_reg;
    logic [15:0] range_max_reg;
    logic [5:0]  sc_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segment_count_reg <= 6'd1;
            range_max_reg     <= 16'hffff;
        end else if (cfg_valid) begin
            if (cfg_index == ucbs_pkg::CFG_SEGMENT_COUNT) begin
                segment_count_reg <= cfg_data[5:0];
            end else begin
                range_max_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        if (segment_count_reg == 6'd0) begin
            sc_eff = 6'd1;
        end else if (segment_count_reg > SC_MAX) begin
            sc_eff = SC_MAX;
        end else begin
            sc_eff = segment_count_reg;
        end
    end

    logic                  adv;
    logic                  item_valid;
    ucbs_pkg::item_t       item;
    ucbs_pkg::div_stage_t  div_out;

    ucbs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .sc_eff     (sc_eff),
        .range_max  (range_max_reg),
        .pop        (adv),
        .item_valid (item_valid),
        .item       (item)
    );

    ucbs_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (item_valid),
        .in_item   (item),
        .range_max (range_max_reg),
        .out_stage (div_out)
    );

    ucbs_blend #(
        .POINTS (POINTS)
    ) u_blend (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .d        (div_out),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* tb/ucbs_checker.sv */
// checker for the uniform cubic b-spline evaluator: watches the load, evaluate,
// config and result channels, predicts each result and compares it; needs ucbs_pkg
`timescale 1ns / 1ps
module ucbs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          clamped_seen
);

    typedef struct {
        logic signed [15:0] value;
        logic [5:0]         seg;
        logic               clamped;
    } spline_result_t;

    spline_result_t       expected_results[$];
    logic signed [15:0]   point_store[64];
    logic [5:0]           seg_count_reg;
    logic [15:0]          range_reg;

    assign pending = expected_results.size();

    function automatic spline_result_t eval_spline(logic [15:0] pos);
        spline_result_t r;
        longint sc, seg, t, s, s3, w0, w1, w2, w3, acc, q, p, rem, den;
        s  = 64'd16384;
        sc = seg_count_reg;
        if (sc == 0) sc = 1;
        if (sc > 61) sc = 61;
        if (range_reg == 0 || pos >= range_reg) begin
            r.clamped = 1'b1;
            seg = sc - 1;
            t = s;
        end else begin
            r.clamped = 1'b0;
            p   = pos * sc;
            seg = p / range_reg;
            rem = p - seg * range_reg;
            t   = (rem << 14) / range_reg;
        end
        s3 = s * s * s;
        w0 = (s - t) * (s - t) * (s - t);
        w1 = 3 * t * t * t - 6 * t * t * s + 4 * s3;
        w2 = -3 * t * t * t + 3 * t * t * s + 3 * t * s * s + s3;
        w3 = t * t * t;
        acc = w0 * point_store[seg] + w1 * point_store[seg + 1]
            + w2 * point_store[seg + 2] + w3 * point_store[seg + 3];
        den = 6 * s3;
        // shift nonnegative so integer division floors, ties go up
        q = (acc + den * 32768 + 3 * s3) / den - 32768;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        r.value = q[15:0];
        r.seg = seg[5:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        spline_result_t want;
        if (!aresetn) begin
            seg_count_reg <= 6'd1;
            range_reg <= 16'hFFFF;
            fail_count <= 0;
            results_seen <= 0;
            clamped_seen <= 0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ucbs_pkg::CFG_SEGMENT_COUNT) seg_count_reg <= cfg_data[5:0];
                else range_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == ucbs_pkg::OP_LOAD) point_store[s_tdata[5:0]] = s_tdata[21:6];
                else expected_results.push_back(eval_spline(s_tdata[37:22]));
            end
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.clamped) clamped_seen <= clamped_seen + 1;
                    if (m_tdata[15:0] !== want.value || m_tdata[21:16] !== want.seg
                            || m_tuser[0] !== want.clamped) begin
                        if (fail_count < 10)
                            $display("mismatch: value %h/%h seg %0d/%0d flag %b/%b",
                                want.value, m_tdata[15:0], want.seg, m_tdata[21:16],
                                want.clamped, m_tuser[0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/tb.sv */
// top of the uniform cubic b-spline evaluator testbench: clock, reset, stimulus
// and verdict; depends on ucbs_pkg, the block and ucbs_checker
`timescale 1ns / 1ps
module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0, s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid, m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0, cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count, pending, results_seen, clamped_seen;
    int          cycle_count = 0;
    bit          hold_off = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_left = 0;
    int          active_points = 4;   // slots 0..active_points-1 are loaded

    uniform_cubic_bspline_eval DUT (.*);

    ucbs_checker checker_i (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** uniform_cubic_bspline_eval: FAILED **");
            $finish;
        end
    end

    // receiver stall pattern, with quiet stretches and one long hold-off
    always @(negedge aclk) begin
        if (hold_off && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= 400;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (cycle_count % 2000 < 500) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_item(logic op, logic [5:0] idx, logic [15:0] val, logic [15:0] pos);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, pos, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        // bursts with random gaps
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    task automatic write_reg(ucbs_pkg::cfg_index_t idx, logic [15:0] val);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // segment count c needs points 0..c+2 loaded
    task automatic set_segments(logic [5:0] c);
        int used;
        used = (c == 0) ? 4 : ((c > 61) ? 64 : c + 3);
        for (int i = 0; i < used; i++)
            send_item(ucbs_pkg::OP_LOAD, i[5:0], 16'($urandom), 16'($urandom));
        write_reg(ucbs_pkg::CFG_SEGMENT_COUNT, 16'(c));
        active_points = used;
    endtask

    task automatic random_eval(logic [15:0] rmax);
        logic [15:0] pos;
        case ($urandom_range(0, 5))
            0: pos = 16'($urandom);
            1: pos = rmax + 16'($urandom_range(0, 3));
            default: pos = (rmax == 0) ? 16'd0 : 16'($urandom_range(0, rmax - 1));
        endcase
        send_item(ucbs_pkg::OP_EVAL, 6'($urandom), 16'($urandom), pos);
    endtask

    initial begin
        logic [15:0] rmax;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, loads, clamping, both config extremes
        set_segments(6'd1);
        send_item(ucbs_pkg::OP_LOAD, 6'd0, 16'h7FFF, 16'hFFFF);
        send_item(ucbs_pkg::OP_LOAD, 6'd1, 16'h8000, 16'h0000);
        send_item(ucbs_pkg::OP_LOAD, 6'd2, 16'h7FFF, 16'h0000);
        send_item(ucbs_pkg::OP_LOAD, 6'd3, 16'h8000, 16'h0000);
        send_item(ucbs_pkg::OP_EVAL, 6'd63, 16'hFFFF, 16'h0000);
        send_item(ucbs_pkg::OP_EVAL, 6'd0, 16'h0000, 16'h7FFF);
        send_item(ucbs_pkg::OP_EVAL, 6'd0, 16'h0000, 16'hFFFE);
        send_item(ucbs_pkg::OP_EVAL, 6'd0, 16'h0000, 16'hFFFF);
        send_item(ucbs_pkg::OP_LOAD, 6'd63, 16'h1234, 16'h0000);
        set_segments(6'd61);
        write_reg(ucbs_pkg::CFG_RANGE_MAX, 16'd1);
        send_item(ucbs_pkg::OP_EVAL, 6'd0, 16'h0000, 16'h0000);
        send_item(ucbs_pkg::OP_EVAL, 6'd0, 16'h0000, 16'h0001);
        write_reg(ucbs_pkg::CFG_RANGE_MAX, 16'd0);
        send_item(ucbs_pkg::OP_EVAL, 6'd0, 16'h0000, 16'h0000);
        set_segments(6'd0);
        set_segments(6'd63);
        write_reg(ucbs_pkg::CFG_RANGE_MAX, 16'hFFFF);
        send_item(ucbs_pkg::OP_EVAL, 6'd0, 16'h0000, 16'hFFFE);
        send_item(ucbs_pkg::OP_EVAL, 6'd0, 16'h0000, 16'hFFFF);

        // random phases with fresh settings
        for (int ph = 0; ph < 8; ph++) begin
            set_segments(6'($urandom_range(0, 63)));
            rmax = (ph == 0) ? 16'hFFFF : 16'($urandom);
            write_reg(ucbs_pkg::CFG_RANGE_MAX, rmax);
            for (int n = 0; n < 140; n++) begin
                if (ph == 3 && n == 20) hold_off = 1'b1;
                if ($urandom_range(0, 4) == 0)
                    send_item(ucbs_pkg::OP_LOAD, 6'($urandom_range(0, active_points - 1)),
                              16'($urandom), 16'($urandom));
                else
                    random_eval(rmax);
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        $display("checked %0d evaluate results, %0d of them clamped, over directed corners",
                 results_seen, clamped_seen);
        $display("and 8 random phases of segment count and range, with one long output stall");
        if (fail_count == 0) begin
            $display("** uniform_cubic_bspline_eval: PASSED **");
        end else begin
            $display("%0d failures", fail_count);
            $display("** uniform_cubic_bspline_eval: FAILED **");
        end
        $finish;
    end
endmodule

/* uniform_cubic_bspline_eval.f */
hdl/ucbs_pkg.sv
hdl/ucbs_front.sv
hdl/ucbs_divider.sv
hdl/ucbs_blend.sv
hdl/uniform_cubic_bspline_eval.sv
tb/ucbs_checker.sv
tb/tb.sv
